@@ sv/ialucc_pkg.sv @@
// ----------------------------------------------------------------------------
// ialucc_pkg
// Shared types, operation codes and constants for the integer ALU with
// condition codes.
// ----------------------------------------------------------------------------
package ialucc_pkg;

    localparam int unsigned DataW  = 32;
    localparam int unsigned FlagW  = 5;

    // flag bit positions
    localparam int unsigned FlagX = 4;
    localparam int unsigned FlagN = 3;
    localparam int unsigned FlagZ = 2;
    localparam int unsigned FlagV = 1;
    localparam int unsigned FlagC = 0;

    localparam logic [DataW-1:0] MaskByte = 32'h0000_00FF;
    localparam logic [DataW-1:0] MaskWord = 32'h0000_FFFF;
    localparam logic [DataW-1:0] MaskLong = 32'hFFFF_FFFF;
    localparam logic [DataW-1:0] MaskHigh = 32'hFFFF_0000;
    localparam logic [DataW-1:0] SignByte = 32'h0000_0080;
    localparam logic [DataW-1:0] SignWord = 32'h0000_8000;
    localparam logic [DataW-1:0] SignLong = 32'h8000_0000;

    typedef enum logic [3:0] {
        CMD_MOVE  = 4'd0,
        CMD_CLR   = 4'd1,
        CMD_NOT   = 4'd2,
        CMD_ADD   = 4'd3,
        CMD_SUB   = 4'd4,
        CMD_CMP   = 4'd5,
        CMD_EXT   = 4'd6,
        CMD_SWAP  = 4'd7,
        CMD_SCC   = 4'd8,
        CMD_DBCC  = 4'd9,
        CMD_BCC   = 4'd10,
        CMD_MOVEQ = 4'd11,
        CMD_MOVEA = 4'd12
    } t_cmd;

    typedef enum logic [1:0] {
        SZ_BYTE = 2'd0,
        SZ_WORD = 2'd1,
        SZ_LONG = 2'd2
    } t_size;

    typedef enum logic [3:0] {
        CC_T  = 4'd0,
        CC_F  = 4'd1,
        CC_HI = 4'd2,
        CC_LS = 4'd3,
        CC_CC = 4'd4,
        CC_CS = 4'd5,
        CC_NE = 4'd6,
        CC_EQ = 4'd7,
        CC_VC = 4'd8,
        CC_VS = 4'd9,
        CC_PL = 4'd10,
        CC_MI = 4'd11,
        CC_GE = 4'd12,
        CC_LT = 4'd13,
        CC_GT = 4'd14,
        CC_LE = 4'd15
    } t_cond;

    typedef struct packed {
        logic [3:0]       cmd;
        logic [1:0]       operand_size;
        logic [DataW-1:0] src_value;
        logic [DataW-1:0] dst_value;
        logic [3:0]       cond_code;
    } t_req;

    typedef struct packed {
        logic [DataW-1:0] result_value;
        logic             write_back;
        logic             branch_taken;
        logic [FlagW-1:0] flags_out;
    } t_res;

endpackage

@@ sv/integer_alu_with_condition_codes_core.sv @@
// ----------------------------------------------------------------------------
// integer_alu_with_condition_codes_core
// Integer ALU, X N Z V C condition codes, one op per cycle when unstalled.
// ----------------------------------------------------------------------------
// usage
//   request channel: i_in_valid / o_in_ready with the operation fields
//     i_cmd, i_operand_size, i_src_value, i_dst_value, i_cond_code
//   result channel: o_out_valid / i_out_ready with o_result_value,
//     o_write_back, o_branch_taken, o_flags_out
//   path: a request taken goes through the input register, one pass of
//     logic and the result register
//   throughput: one request per cycle while results drain; the flag
//     register is written as a request moves into the result register, so
//     the next request sees the new flags with no bubble
//   stall: while a result waits, one more request is still taken into the
//     input register; o_in_ready drops only when both registers are full
//   reset: synchronous, active low; both registers empty, flags cleared
// ----------------------------------------------------------------------------
module integer_alu_with_condition_codes_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [3:0]  i_cmd,
    input  logic [1:0]  i_operand_size,
    input  logic [31:0] i_src_value,
    input  logic [31:0] i_dst_value,
    input  logic [3:0]  i_cond_code,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_result_value,
    output logic        o_write_back,
    output logic        o_branch_taken,
    output logic [4:0]  o_flags_out
);

    // input register
    logic                         r_in_valid;
    ialucc_pkg::t_req             r_req;
    // result register
    logic                         r_out_valid;
    ialucc_pkg::t_res             r_res;
    // architectural flags
    logic [ialucc_pkg::FlagW-1:0] r_flags;

    ialucc_pkg::t_res             n_res;
    logic                         advance;
    logic                         take;

    // request moves to the result register when that one is free or drains
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;
    assign take       = i_in_valid && o_in_ready;

    ialucc_exec u_exec (
        .i_req   (r_req),
        .i_flags (r_flags),
        .o_res   (n_res)
    );

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_flags     <= '0;
        end else begin
            if (take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_flags     <= n_res.flags_out;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_req.cmd          <= i_cmd;
            r_req.operand_size <= i_operand_size;
            r_req.src_value    <= i_src_value;
            r_req.dst_value    <= i_dst_value;
            r_req.cond_code    <= i_cond_code;
        end
        if (advance) begin
            r_res <= n_res;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_result_value = r_res.result_value;
    assign o_write_back   = r_res.write_back;
    assign o_branch_taken = r_res.branch_taken;
    assign o_flags_out    = r_res.flags_out;

endmodule

@@ sv/ialucc_exec.sv @@
// ----------------------------------------------------------------------------
// ialucc_exec
// Single-pass datapath: result value, write-back, branch decision and new
// flags for one request, given the current flags.
// ----------------------------------------------------------------------------
module ialucc_exec (
    input  ialucc_pkg::t_req                   i_req,
    input  logic [ialucc_pkg::FlagW-1:0]       i_flags,
    output ialucc_pkg::t_res                   o_res
);

    logic [ialucc_pkg::DataW-1:0] m;
    logic [ialucc_pkg::DataW-1:0] sg;
    logic [ialucc_pkg::DataW-1:0] s;
    logic [ialucc_pkg::DataW-1:0] d;
    logic [ialucc_pkg::DataW-1:0] sm;
    logic [ialucc_pkg::DataW-1:0] dm;
    logic [ialucc_pkg::DataW:0]   sum;
    logic [ialucc_pkg::DataW-1:0] r_add;
    logic [ialucc_pkg::DataW-1:0] r_sub;
    logic [ialucc_pkg::DataW-1:0] r_tmp;
    logic [15:0]                  dec;
    logic                         fc, fv, fz, fn, fx;
    logic                         ct;
    logic [ialucc_pkg::DataW-1:0] res;
    logic                         wb, br;
    logic [ialucc_pkg::FlagW-1:0] f;

    // size mask and sign bit, size code three acts as long
    always_comb begin
        case (ialucc_pkg::t_size'(i_req.operand_size))
            ialucc_pkg::SZ_BYTE: begin
                m  = ialucc_pkg::MaskByte;
                sg = ialucc_pkg::SignByte;
            end
            ialucc_pkg::SZ_WORD: begin
                m  = ialucc_pkg::MaskWord;
                sg = ialucc_pkg::SignWord;
            end
            default: begin
                m  = ialucc_pkg::MaskLong;
                sg = ialucc_pkg::SignLong;
            end
        endcase
    end

    assign s  = i_req.src_value;
    assign d  = i_req.dst_value;
    assign sm = s & m;
    assign dm = d & m;
    assign sum   = {1'b0, dm} + {1'b0, sm};
    assign r_add = sum[ialucc_pkg::DataW-1:0] & m;
    assign r_sub = (dm - sm) & m;
    assign dec   = d[15:0] - 16'd1;

    assign fc = i_flags[ialucc_pkg::FlagC];
    assign fv = i_flags[ialucc_pkg::FlagV];
    assign fz = i_flags[ialucc_pkg::FlagZ];
    assign fn = i_flags[ialucc_pkg::FlagN];
    assign fx = i_flags[ialucc_pkg::FlagX];

    // condition test on the current flags
    always_comb begin
        case (ialucc_pkg::t_cond'(i_req.cond_code))
            ialucc_pkg::CC_T:  ct = 1'b1;
            ialucc_pkg::CC_F:  ct = 1'b0;
            ialucc_pkg::CC_HI: ct = !fc && !fz;
            ialucc_pkg::CC_LS: ct = fc || fz;
            ialucc_pkg::CC_CC: ct = !fc;
            ialucc_pkg::CC_CS: ct = fc;
            ialucc_pkg::CC_NE: ct = !fz;
            ialucc_pkg::CC_EQ: ct = fz;
            ialucc_pkg::CC_VC: ct = !fv;
            ialucc_pkg::CC_VS: ct = fv;
            ialucc_pkg::CC_PL: ct = !fn;
            ialucc_pkg::CC_MI: ct = fn;
            ialucc_pkg::CC_GE: ct = (fn == fv);
            ialucc_pkg::CC_LT: ct = (fn != fv);
            ialucc_pkg::CC_GT: ct = !fz && (fn == fv);
            default:           ct = fz || (fn != fv);
        endcase
    end

    always_comb begin
        res   = d;
        wb    = 1'b0;
        br    = 1'b0;
        f     = i_flags;
        r_tmp = '0;
        case (ialucc_pkg::t_cmd'(i_req.cmd))
            ialucc_pkg::CMD_MOVE: begin
                r_tmp = sm;
                res   = (d & ~m) | r_tmp;
                wb    = 1'b1;
                f     = {fx, |(r_tmp & sg), ~|r_tmp, 2'b00};
            end
            ialucc_pkg::CMD_CLR: begin
                res = d & ~m;
                wb  = 1'b1;
                f   = {fx, 1'b0, 1'b1, 2'b00};
            end
            ialucc_pkg::CMD_NOT: begin
                r_tmp = ~d & m;
                res   = (d & ~m) | r_tmp;
                wb    = 1'b1;
                f     = {fx, |(r_tmp & sg), ~|r_tmp, 2'b00};
            end
            ialucc_pkg::CMD_ADD: begin
                res = (d & ~m) | r_add;
                wb  = 1'b1;
                f   = {sum > {1'b0, m}, |(r_add & sg), ~|r_add,
                       |(~(s ^ d) & (r_add ^ d) & sg), sum > {1'b0, m}};
            end
            ialucc_pkg::CMD_SUB: begin
                res = (d & ~m) | r_sub;
                wb  = 1'b1;
                f   = {sm > dm, |(r_sub & sg), ~|r_sub,
                       |((s ^ d) & (r_sub ^ d) & sg), sm > dm};
            end
            ialucc_pkg::CMD_CMP: begin
                f = {fx, |(r_sub & sg), ~|r_sub,
                     |((s ^ d) & (r_sub ^ d) & sg), sm > dm};
            end
            ialucc_pkg::CMD_EXT: begin
                case (ialucc_pkg::t_size'(i_req.operand_size))
                    ialucc_pkg::SZ_BYTE: begin
                        r_tmp = {16'h0000, {8{d[7]}}, d[7:0]};
                        res   = (d & ialucc_pkg::MaskHigh) | r_tmp;
                        wb    = 1'b1;
                        f     = {fx, r_tmp[15], ~|r_tmp[15:0], 2'b00};
                    end
                    ialucc_pkg::SZ_WORD: begin
                        r_tmp = {{16{d[15]}}, d[15:0]};
                        res   = r_tmp;
                        wb    = 1'b1;
                        f     = {fx, r_tmp[31], ~|r_tmp, 2'b00};
                    end
                    default: begin
                        res = d;
                    end
                endcase
            end
            ialucc_pkg::CMD_SWAP: begin
                r_tmp = {d[15:0], d[31:16]};
                res   = r_tmp;
                wb    = 1'b1;
                f     = {fx, r_tmp[31], ~|r_tmp, 2'b00};
            end
            ialucc_pkg::CMD_SCC: begin
                res = {d[31:8], {8{ct}}};
                wb  = 1'b1;
                br  = ct;
            end
            ialucc_pkg::CMD_DBCC: begin
                if (!ct) begin
                    res = {d[31:16], dec};
                    wb  = 1'b1;
                    br  = (dec != 16'hFFFF);
                end
            end
            ialucc_pkg::CMD_BCC: begin
                br = ct;
            end
            ialucc_pkg::CMD_MOVEQ: begin
                r_tmp = {{24{s[7]}}, s[7:0]};
                res   = r_tmp;
                wb    = 1'b1;
                f     = {fx, r_tmp[31], ~|r_tmp, 2'b00};
            end
            ialucc_pkg::CMD_MOVEA: begin
                if (ialucc_pkg::t_size'(i_req.operand_size) == ialucc_pkg::SZ_WORD) begin
                    res = {{16{s[15]}}, s[15:0]};
                end else begin
                    res = s;
                end
                wb = 1'b1;
            end
            default: begin
                res = d;
            end
        endcase
    end

    assign o_res.result_value = res;
    assign o_res.write_back   = wb;
    assign o_res.branch_taken = br;
    assign o_res.flags_out    = f;

endmodule

@@ sv/ialucc_checker.sv @@
// ----------------------------------------------------------------------------
// ialucc_checker
// Port-level checks for the integer ALU core, bound to the top level.
// ----------------------------------------------------------------------------
module ialucc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic [3:0]  i_cmd,
    input logic [1:0]  i_operand_size,
    input logic [31:0] i_src_value,
    input logic [31:0] i_dst_value,
    input logic [3:0]  i_cond_code,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [31:0] o_result_value,
    input logic        o_write_back,
    input logic        o_branch_taken,
    input logic [4:0]  o_flags_out
);

    // stalled result stays and holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_result_value)
            && $stable(o_write_back) && $stable(o_branch_taken)
            && $stable(o_flags_out))
        else $error("result changed while stalled");

    // requests are refused only when a result is waiting
    a_ready_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid && !i_out_ready)
        else $error("request refused with free result register");

    // empty and ready on the edge after any reset edge
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("not empty after reset");

    // a request with both registers empty goes through them to o_out_valid
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && !o_out_valid && $past(i_rst_n)
            && !$past(i_in_valid && o_in_ready) |=> ##1 o_out_valid)
        else $error("result missing after two cycles");

endmodule

bind integer_alu_with_condition_codes_core ialucc_checker u_ialucc_checker (.*);

@@ sim/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the integer ALU with condition codes. A class-based
// tracker keeps its own copy of the X N Z V C flags, predicts every accepted
// request and matches the results in order. Directed corner requests come
// first, then three random phases with different idle patterns on each side.
// ----------------------------------------------------------------------------
module tb;

    // codes outside the package enums that the bench still drives
    localparam logic [3:0] CMD_UNUSED_LO = 4'd13;
    localparam logic [3:0] CMD_UNUSED_HI = 4'd15;
    localparam logic [1:0] SIZE_THREE    = 2'd3;

    // clock, reset and block ports; the inputs are known from time zero
    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_in_valid     = 1'b0;
    logic        o_in_ready;
    logic [3:0]  i_cmd          = '0;
    logic [1:0]  i_operand_size = '0;
    logic [31:0] i_src_value    = '0;
    logic [31:0] i_dst_value    = '0;
    logic [3:0]  i_cond_code    = '0;
    logic        o_out_valid;
    logic        i_out_ready    = 1'b0;
    logic [31:0] o_result_value;
    logic        o_write_back;
    logic        o_branch_taken;
    logic [4:0]  o_flags_out;

    // idle chance per cycle, in percent, for each side
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;

    // tracks the flags and the results still owed by the block
    class alu_result_book;
        logic [ialucc_pkg::FlagW-1:0] ccr_flags;
        ialucc_pkg::t_res             owed_results[$];
        int                           mismatches;

        function new();
            ccr_flags  = '0;
            mismatches = 0;
        endfunction

        function logic cond_holds(logic [ialucc_pkg::FlagW-1:0] f, logic [3:0] cc);
            logic c, v, z, n;
            c = f[ialucc_pkg::FlagC];
            v = f[ialucc_pkg::FlagV];
            z = f[ialucc_pkg::FlagZ];
            n = f[ialucc_pkg::FlagN];
            case (cc)
                ialucc_pkg::CC_T:  return 1'b1;
                ialucc_pkg::CC_F:  return 1'b0;
                ialucc_pkg::CC_HI: return !c && !z;
                ialucc_pkg::CC_LS: return c || z;
                ialucc_pkg::CC_CC: return !c;
                ialucc_pkg::CC_CS: return c;
                ialucc_pkg::CC_NE: return !z;
                ialucc_pkg::CC_EQ: return z;
                ialucc_pkg::CC_VC: return !v;
                ialucc_pkg::CC_VS: return v;
                ialucc_pkg::CC_PL: return !n;
                ialucc_pkg::CC_MI: return n;
                ialucc_pkg::CC_GE: return n == v;
                ialucc_pkg::CC_LT: return n != v;
                ialucc_pkg::CC_GT: return !z && (n == v);
                default:           return z || (n != v);
            endcase
        endfunction

        // keep x, take n and z from the sized value, clear v and c
        function logic [ialucc_pkg::FlagW-1:0] nz_flags(logic x, logic [31:0] v,
                                                        logic [31:0] m, logic [31:0] sg);
            logic [ialucc_pkg::FlagW-1:0] f;
            f                   = '0;
            f[ialucc_pkg::FlagX] = x;
            f[ialucc_pkg::FlagN] = (v & sg) != 0;
            f[ialucc_pkg::FlagZ] = (v & m) == 0;
            return f;
        endfunction

        function ialucc_pkg::t_res execute_op(ialucc_pkg::t_req r);
            logic [31:0]                  m, sg, s, d, res, rv;
            logic [32:0]                  sum;
            logic [ialucc_pkg::FlagW-1:0] f;
            logic                         x_keep, ct, wb, br;
            ialucc_pkg::t_res             o;
            s = r.src_value;
            d = r.dst_value;
            case (r.operand_size)
                ialucc_pkg::SZ_BYTE: begin
                    m  = ialucc_pkg::MaskByte;
                    sg = ialucc_pkg::SignByte;
                end
                ialucc_pkg::SZ_WORD: begin
                    m  = ialucc_pkg::MaskWord;
                    sg = ialucc_pkg::SignWord;
                end
                default: begin
                    m  = ialucc_pkg::MaskLong;
                    sg = ialucc_pkg::SignLong;
                end
            endcase
            f      = ccr_flags;
            x_keep = f[ialucc_pkg::FlagX];
            ct     = cond_holds(f, r.cond_code);
            res    = d;
            wb     = 1'b0;
            br     = 1'b0;
            case (r.cmd)
                ialucc_pkg::CMD_MOVE: begin
                    rv  = s & m;
                    res = (d & ~m) | rv;
                    wb  = 1'b1;
                    f   = nz_flags(x_keep, rv, m, sg);
                end
                ialucc_pkg::CMD_CLR: begin
                    res                  = d & ~m;
                    wb                   = 1'b1;
                    f                    = '0;
                    f[ialucc_pkg::FlagX] = x_keep;
                    f[ialucc_pkg::FlagZ] = 1'b1;
                end
                ialucc_pkg::CMD_NOT: begin
                    rv  = ~d & m;
                    res = (d & ~m) | rv;
                    wb  = 1'b1;
                    f   = nz_flags(x_keep, rv, m, sg);
                end
                ialucc_pkg::CMD_ADD: begin
                    sum = {1'b0, d & m} + {1'b0, s & m};
                    rv  = sum[31:0] & m;
                    res = (d & ~m) | rv;
                    wb  = 1'b1;
                    f   = nz_flags(1'b0, rv, m, sg);
                    if (sum > {1'b0, m}) begin
                        f[ialucc_pkg::FlagC] = 1'b1;
                        f[ialucc_pkg::FlagX] = 1'b1;
                    end
                    if ((~(s ^ d) & (rv ^ d) & sg) != 0) f[ialucc_pkg::FlagV] = 1'b1;
                end
                ialucc_pkg::CMD_SUB, ialucc_pkg::CMD_CMP: begin
                    rv = ((d & m) - (s & m)) & m;
                    if (r.cmd == ialucc_pkg::CMD_SUB) begin
                        res = (d & ~m) | rv;
                        wb  = 1'b1;
                        f   = nz_flags(1'b0, rv, m, sg);
                    end else begin
                        f   = nz_flags(x_keep, rv, m, sg);
                    end
                    // borrow; only sub copies it into x
                    if ((s & m) > (d & m)) begin
                        f[ialucc_pkg::FlagC] = 1'b1;
                        if (r.cmd == ialucc_pkg::CMD_SUB) f[ialucc_pkg::FlagX] = 1'b1;
                    end
                    if (((s ^ d) & (rv ^ d) & sg) != 0) f[ialucc_pkg::FlagV] = 1'b1;
                end
                ialucc_pkg::CMD_EXT: begin
                    case (r.operand_size)
                        ialucc_pkg::SZ_BYTE: begin
                            rv = d & ialucc_pkg::MaskByte;
                            if (d[7]) rv = rv | (ialucc_pkg::MaskWord & ~ialucc_pkg::MaskByte);
                            res = (d & ialucc_pkg::MaskHigh) | rv;
                            wb  = 1'b1;
                            f   = nz_flags(x_keep, rv, ialucc_pkg::MaskWord,
                                           ialucc_pkg::SignWord);
                        end
                        ialucc_pkg::SZ_WORD: begin
                            rv = d & ialucc_pkg::MaskWord;
                            if (d[15]) rv = rv | ialucc_pkg::MaskHigh;
                            res = rv;
                            wb  = 1'b1;
                            f   = nz_flags(x_keep, rv, ialucc_pkg::MaskLong,
                                           ialucc_pkg::SignLong);
                        end
                        default: ;
                    endcase
                end
                ialucc_pkg::CMD_SWAP: begin
                    rv  = {d[15:0], d[31:16]};
                    res = rv;
                    wb  = 1'b1;
                    f   = nz_flags(x_keep, rv, ialucc_pkg::MaskLong, ialucc_pkg::SignLong);
                end
                ialucc_pkg::CMD_SCC: begin
                    res = (d & ~ialucc_pkg::MaskByte) | (ct ? ialucc_pkg::MaskByte : 32'h0);
                    wb  = 1'b1;
                    br  = ct;
                end
                ialucc_pkg::CMD_DBCC: begin
                    // loop counter runs on a false condition only
                    if (!ct) begin
                        rv  = ((d & ialucc_pkg::MaskWord) - 32'd1) & ialucc_pkg::MaskWord;
                        res = (d & ialucc_pkg::MaskHigh) | rv;
                        wb  = 1'b1;
                        br  = rv != ialucc_pkg::MaskWord;
                    end
                end
                ialucc_pkg::CMD_BCC: br = ct;
                ialucc_pkg::CMD_MOVEQ: begin
                    rv = s & ialucc_pkg::MaskByte;
                    if (s[7]) rv = rv | ~ialucc_pkg::MaskByte;
                    res = rv;
                    wb  = 1'b1;
                    f   = nz_flags(x_keep, rv, ialucc_pkg::MaskLong, ialucc_pkg::SignLong);
                end
                ialucc_pkg::CMD_MOVEA: begin
                    if (r.operand_size == ialucc_pkg::SZ_WORD) begin
                        rv = s & ialucc_pkg::MaskWord;
                        if (s[15]) rv = rv | ialucc_pkg::MaskHigh;
                    end else begin
                        rv = s;
                    end
                    res = rv;
                    wb  = 1'b1;
                end
                default: ;
            endcase
            ccr_flags      = f;
            o.result_value = res;
            o.write_back   = wb;
            o.branch_taken = br;
            o.flags_out    = f;
            return o;
        endfunction

        function void take_request(ialucc_pkg::t_req r);
            owed_results.push_back(execute_op(r));
        endfunction

        function int outstanding();
            return owed_results.size();
        endfunction

        task report_mismatch(string what);
            $display("mismatch: %s", what);
            mismatches++;
        endtask

        task match_result(ialucc_pkg::t_res got);
            ialucc_pkg::t_res want;
            if (owed_results.size() == 0) begin
                report_mismatch($sformatf("result %h with no request waiting",
                                          got.result_value));
                return;
            end
            want = owed_results.pop_front();
            if (got.result_value !== want.result_value)
                report_mismatch($sformatf("result_value expected %h got %h",
                                          want.result_value, got.result_value));
            if (got.write_back !== want.write_back)
                report_mismatch($sformatf("write_back expected %b got %b",
                                          want.write_back, got.write_back));
            if (got.branch_taken !== want.branch_taken)
                report_mismatch($sformatf("branch_taken expected %b got %b",
                                          want.branch_taken, got.branch_taken));
            if (got.flags_out !== want.flags_out)
                report_mismatch($sformatf("flags_out expected %b got %b",
                                          want.flags_out, got.flags_out));
        endtask

        task flush_check();
            if (owed_results.size() != 0)
                report_mismatch($sformatf("%0d results never arrived",
                                          owed_results.size()));
        endtask
    endclass

    alu_result_book book = new();

    integer_alu_with_condition_codes_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_cmd          (i_cmd),
        .i_operand_size (i_operand_size),
        .i_src_value    (i_src_value),
        .i_dst_value    (i_dst_value),
        .i_cond_code    (i_cond_code),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_result_value (o_result_value),
        .o_write_back   (o_write_back),
        .o_branch_taken (o_branch_taken),
        .o_flags_out    (o_flags_out)
    );

    always #4 i_clk = ~i_clk;

    // result side: values sampled at the edge are the pre-edge ones
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            book.match_result({o_result_value, o_write_back, o_branch_taken, o_flags_out});
        i_out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // one request: optional gap, then hold valid until the block takes it
    task automatic send_request(input ialucc_pkg::t_req req);
        if ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < tx_idle_pct) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_cmd          <= req.cmd;
        i_operand_size <= req.operand_size;
        i_src_value    <= req.src_value;
        i_dst_value    <= req.dst_value;
        i_cond_code    <= req.cond_code;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        book.take_request(req);
    endtask

    task automatic send_op(input logic [3:0] cmd, input logic [1:0] sz,
                           input logic [31:0] s, input logic [31:0] d,
                           input logic [3:0] cc);
        ialucc_pkg::t_req req;
        req.cmd          = cmd;
        req.operand_size = sz;
        req.src_value    = s;
        req.dst_value    = d;
        req.cond_code    = cc;
        send_request(req);
    endtask

    // sender holds off until every owed result has come back
    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (book.outstanding() != 0) @(posedge i_clk);
    endtask

    function automatic logic [31:0] corner_value(int k);
        case (k)
            0:       return 32'h0000_0000;
            1:       return 32'h0000_0001;
            2:       return 32'h0000_007F;
            3:       return 32'h0000_0080;
            4:       return 32'h0000_00FF;
            5:       return 32'h0000_7FFF;
            6:       return 32'h0000_8000;
            7:       return 32'hABCD_0000;
            8:       return 32'h7FFF_FFFF;
            9:       return 32'h8000_0000;
            default: return 32'hFFFF_FFFF;
        endcase
    endfunction

    // a quarter of operands are corners, the rest fully random
    function automatic logic [31:0] pick_operand();
        if ($urandom_range(3) == 0) return corner_value($urandom_range(10));
        return $urandom;
    endfunction

    task automatic run_random(input int count);
        ialucc_pkg::t_req req;
        repeat (count) begin
            // unused command codes now and then, the real set otherwise
            if ($urandom_range(24) == 0)
                req.cmd = 4'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
            else
                req.cmd = 4'($urandom_range(ialucc_pkg::CMD_MOVE, ialucc_pkg::CMD_MOVEA));
            req.operand_size = 2'($urandom_range(ialucc_pkg::SZ_BYTE, SIZE_THREE));
            req.src_value    = pick_operand();
            req.dst_value    = pick_operand();
            req.cond_code    = 4'($urandom_range(ialucc_pkg::CC_T, ialucc_pkg::CC_LE));
            // equal operands reach the zero result of sub and cmp
            if ($urandom_range(7) == 0) req.src_value = req.dst_value;
            send_request(req);
        end
    endtask

    task automatic run_directed();
        // sized moves: negative byte, zero long
        send_op(ialucc_pkg::CMD_MOVE, ialucc_pkg::SZ_BYTE,
                32'h0000_0080, 32'h1234_5678, ialucc_pkg::CC_T);
        send_op(ialucc_pkg::CMD_MOVE, ialucc_pkg::SZ_LONG,
                32'h0000_0000, 32'hFFFF_FFFF, ialucc_pkg::CC_T);
        send_op(ialucc_pkg::CMD_CLR, ialucc_pkg::SZ_WORD,
                32'h0000_0000, 32'hFFFF_FFFF, ialucc_pkg::CC_T);
        send_op(ialucc_pkg::CMD_NOT, ialucc_pkg::SZ_LONG,
                32'h0000_0000, 32'h0000_0000, ialucc_pkg::CC_T);
        // carries out of byte and long, long one from the wide sum; word overflow
        send_op(ialucc_pkg::CMD_ADD, ialucc_pkg::SZ_BYTE,
                32'h0000_0001, 32'hAAAA_AAFF, ialucc_pkg::CC_T);
        send_op(ialucc_pkg::CMD_ADD, ialucc_pkg::SZ_LONG,
                32'h0000_0001, 32'hFFFF_FFFF, ialucc_pkg::CC_T);
        send_op(ialucc_pkg::CMD_ADD, ialucc_pkg::SZ_WORD,
                32'h0000_0001, 32'h0000_7FFF, ialucc_pkg::CC_T);
        // borrow and signed overflow
        send_op(ialucc_pkg::CMD_SUB, ialucc_pkg::SZ_BYTE,
                32'h0000_0001, 32'h0000_0000, ialucc_pkg::CC_T);
        send_op(ialucc_pkg::CMD_SUB, ialucc_pkg::SZ_LONG,
                32'h0000_0001, 32'h8000_0000, ialucc_pkg::CC_T);
        // compare overflows the same way as sub, x kept
        send_op(ialucc_pkg::CMD_CMP, ialucc_pkg::SZ_LONG,
                32'h0000_0001, 32'h8000_0000, ialucc_pkg::CC_T);
        send_op(ialucc_pkg::CMD_BCC, ialucc_pkg::SZ_LONG,
                32'h0000_0000, 32'h0000_0000, ialucc_pkg::CC_VS);
        send_op(ialucc_pkg::CMD_EXT, ialucc_pkg::SZ_BYTE,
                32'h0000_0000, 32'h1234_0080, ialucc_pkg::CC_T);
        send_op(ialucc_pkg::CMD_EXT, ialucc_pkg::SZ_WORD,
                32'h0000_0000, 32'h0000_8000, ialucc_pkg::CC_T);
        // ext at long and at size three is a no-op
        send_op(ialucc_pkg::CMD_EXT, ialucc_pkg::SZ_LONG,
                32'h0000_0000, 32'h0000_8000, ialucc_pkg::CC_T);
        send_op(ialucc_pkg::CMD_EXT, SIZE_THREE,
                32'h0000_0000, 32'h0000_0080, ialucc_pkg::CC_T);
        send_op(ialucc_pkg::CMD_SWAP, ialucc_pkg::SZ_BYTE,
                32'h0000_0000, 32'h8000_1234, ialucc_pkg::CC_T);
        send_op(ialucc_pkg::CMD_SCC, ialucc_pkg::SZ_BYTE,
                32'h0000_0000, 32'h1234_5678, ialucc_pkg::CC_T);
        send_op(ialucc_pkg::CMD_SCC, ialucc_pkg::SZ_BYTE,
                32'h0000_0000, 32'h1234_56FF, ialucc_pkg::CC_F);
        // loop counter: wrap to all ones, plain decrement, true condition
        send_op(ialucc_pkg::CMD_DBCC, ialucc_pkg::SZ_WORD,
                32'h0000_0000, 32'h5555_0000, ialucc_pkg::CC_F);
        send_op(ialucc_pkg::CMD_DBCC, ialucc_pkg::SZ_WORD,
                32'h0000_0000, 32'h5555_0005, ialucc_pkg::CC_F);
        send_op(ialucc_pkg::CMD_DBCC, ialucc_pkg::SZ_WORD,
                32'h0000_0000, 32'h5555_0005, ialucc_pkg::CC_T);
        send_op(ialucc_pkg::CMD_MOVEQ, ialucc_pkg::SZ_WORD,
                32'hFFFF_FF80, 32'h0000_0000, ialucc_pkg::CC_T);
        send_op(ialucc_pkg::CMD_MOVEA, ialucc_pkg::SZ_WORD,
                32'h0000_8000, 32'h0000_0000, ialucc_pkg::CC_T);
        send_op(ialucc_pkg::CMD_MOVEA, ialucc_pkg::SZ_BYTE,
                32'h1234_5678, 32'h0000_0000, ialucc_pkg::CC_T);
        // size three add acts as long
        send_op(ialucc_pkg::CMD_ADD, SIZE_THREE,
                32'h8000_0000, 32'h8000_0000, ialucc_pkg::CC_T);
        send_op(CMD_UNUSED_LO, ialucc_pkg::SZ_LONG,
                32'hFFFF_FFFF, 32'h0F0F_0F0F, ialucc_pkg::CC_LE);
        send_op(CMD_UNUSED_HI, ialucc_pkg::SZ_BYTE,
                32'h0000_0000, 32'hF0F0_F0F0, ialucc_pkg::CC_GT);
    endtask

    initial begin : stimulus
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // phase one: slow result side
        tx_idle_pct = 28;
        rx_idle_pct = 82;
        run_directed();
        run_random(170);
        drain_results();

        // phase two: slow request side
        tx_idle_pct = 82;
        rx_idle_pct = 28;
        run_random(170);
        drain_results();

        // phase three: back to back
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        run_random(160);
        drain_results();

        // catch any stray result past the last owed one
        repeat (10) @(posedge i_clk);
        book.flush_check();
        if (book.mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin : watchdog
        #(8 * 400000);
        $display("== FAIL ==");
        $finish;
    end

endmodule

@@ integer_alu_with_condition_codes_core.f @@
sv/ialucc_pkg.sv
sv/ialucc_exec.sv
sv/integer_alu_with_condition_codes_core.sv
sv/ialucc_checker.sv
sim/tb.sv
